// ----- rtl/ccr_pkg.sv -----
// Package for the CRC-8 framed command receiver.
// Beat types, status and kind codes, and the CRC-8 byte update.
// No dependencies.
`default_nettype none

package ccr_pkg;

    localparam int unsigned CAP_DEPTH = 5;
    localparam logic [7:0]  CRC_POLY  = 8'hD8;
    localparam logic [7:0]  CTRL_START_RST = 8'hAA;
    localparam logic [7:0]  PARA_START_RST = 8'h55;

    localparam logic        KIND_CTRL = 1'b0;
    localparam logic        KIND_PARA = 1'b1;

    localparam logic [1:0]  STATUS_OK      = 2'd0;
    localparam logic [1:0]  STATUS_CRC_ERR = 2'd1;
    localparam logic [1:0]  STATUS_REFUSED = 2'd2;

    localparam logic        REG_CTRL_START = 1'b0;
    localparam logic        REG_PARA_START = 1'b1;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       panic_mode;
    } in_beat_t;

    typedef struct packed {
        logic       frame_kind;
        logic [1:0] frame_status;
        logic [7:0] computed_crc;
        logic [7:0] param_index;
        logic [7:0] data_byte0;
        logic [7:0] data_byte1;
        logic [7:0] data_byte2;
        logic [7:0] data_byte3;
    } out_beat_t;

    // MSB-first CRC-8 over one byte
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        r = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (r[7])
                r = {r[6:0], 1'b0} ^ CRC_POLY;
            else
                r = {r[6:0], 1'b0};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ccr_if.sv -----
// Valid/ready channel interfaces for the receiver's byte input and result output.
// Depends on ccr_pkg.
`default_nettype none

interface ccr_in_if;
    logic               valid;
    logic               ready;
    ccr_pkg::in_beat_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ccr_out_if;
    logic               valid;
    logic               ready;
    ccr_pkg::out_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/crc8_framed_command_receiver_core.sv -----
// Top level of the CRC-8 framed command receiver.
// Depends on ccr_pkg and the channel interfaces in ccr_if.sv.
//
// Takes one received byte per beat, one beat per clock while ready is high. Idle until
// a start byte (control or parameter, control wins if equal), then CTRL_LEN or
// PARA_LEN data bytes, then a CRC byte. The CRC-8 (poly 0xD8, MSB first, init 0) is
// updated on the start and data bytes in the same cycle each is taken. The CRC byte
// produces one result beat in the output register; other bytes produce nothing. Input
// ready drops only while a result sits in the output register and the sink holds ready
// low. Start bytes may be rewritten through the cfg port while no frame is open.
`default_nettype none

module crc8_framed_command_receiver_core #(
    parameter int unsigned CTRL_LEN = 4,
    parameter int unsigned PARA_LEN = 5
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    ccr_in_if.sink          in_ch,
    ccr_out_if.source       out_ch,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_wdata
);
    import ccr_pkg::*;

    localparam logic [5:0] CTRL_LEN_C = 6'(CTRL_LEN);
    localparam logic [5:0] PARA_LEN_C = 6'(PARA_LEN);
    localparam logic [5:0] MAX_LEN_C  = (CTRL_LEN > PARA_LEN) ? CTRL_LEN_C : PARA_LEN_C;
    localparam logic [5:0] CAP_DEPTH_C = 6'(CAP_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_CTRL = 2'd1,
        ST_PARA = 2'd2
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] count_reg, count_next;
    logic [7:0] crc_reg, crc_next;
    logic [7:0] ctrl_start_reg;
    logic [7:0] para_start_reg;
    logic       out_valid_reg, out_valid_next;
    out_beat_t  out_data_reg, out_data_next;
    logic [7:0] cap_reg [CAP_DEPTH];

    logic       accept;
    logic       frame_end;
    logic       cap_we;
    logic       is_para;
    logic [5:0] len;
    logic [7:0] crc_upd;
    in_beat_t   beat;

    assign beat         = in_ch.data;
    assign in_ch.ready  = !out_valid_reg || out_ch.ready;
    assign accept       = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    assign is_para   = (state_reg == ST_PARA);
    assign len       = is_para ? PARA_LEN_C : CTRL_LEN_C;
    assign crc_upd   = crc8_update(crc_reg, beat.rx_byte);
    assign frame_end = accept && (state_reg == ST_CTRL || state_reg == ST_PARA)
                       && (count_reg >= len);
    assign cap_we    = accept && (state_reg == ST_CTRL || state_reg == ST_PARA)
                       && (count_reg < len) && (count_reg < CAP_DEPTH_C);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_data_next  = out_data_reg;

        if (accept)
        begin
            case (state_reg)
                ST_CTRL, ST_PARA:
                begin
                    if (count_reg < len)
                    begin
                        crc_next   = crc_upd;
                        count_next = count_reg + 6'd1;
                    end
                    else
                    begin
                        out_valid_next             = 1'b1;
                        out_data_next.frame_kind   = is_para ? KIND_PARA : KIND_CTRL;
                        out_data_next.computed_crc = crc_reg;
                        if (beat.rx_byte != crc_reg)
                            out_data_next.frame_status = STATUS_CRC_ERR;
                        else if (is_para && beat.panic_mode)
                            out_data_next.frame_status = STATUS_REFUSED;
                        else
                            out_data_next.frame_status = STATUS_OK;
                        if (is_para)
                        begin
                            out_data_next.param_index = cap_reg[0];
                            out_data_next.data_byte0  = cap_reg[1];
                            out_data_next.data_byte1  = cap_reg[2];
                            out_data_next.data_byte2  = cap_reg[3];
                            out_data_next.data_byte3  = cap_reg[4];
                        end
                        else
                        begin
                            out_data_next.param_index = 8'd0;
                            out_data_next.data_byte0  = cap_reg[0];
                            out_data_next.data_byte1  = cap_reg[1];
                            out_data_next.data_byte2  = cap_reg[2];
                            out_data_next.data_byte3  = cap_reg[3];
                        end
                        state_next = ST_IDLE;
                        count_next = 6'd0;
                        crc_next   = 8'd0;
                    end
                end
                default:
                begin
                    // idle, and the unused code
                    if (beat.rx_byte == ctrl_start_reg)
                    begin
                        state_next = ST_CTRL;
                        crc_next   = crc8_update(8'd0, beat.rx_byte);
                    end
                    else if (beat.rx_byte == para_start_reg)
                    begin
                        state_next = ST_PARA;
                        crc_next   = crc8_update(8'd0, beat.rx_byte);
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                    count_next = 6'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= 6'd0;
            crc_reg        <= 8'd0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            ctrl_start_reg <= CTRL_START_RST;
            para_start_reg <= PARA_START_RST;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CTRL_START: ctrl_start_reg <= cfg_wdata;
                    REG_PARA_START: para_start_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // capture buffer, no reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAP_DEPTH; i++)
        begin
            if (cap_we && (count_reg == 6'(i)))
                cap_reg[i] <= beat.rx_byte;
        end
    end

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (count_reg == 6'd0 && crc_reg == 8'd0))
        else $error("idle with nonzero count or crc");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_LEN_C)
        else $error("byte count past frame length");

    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        frame_end |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("frame end without result");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_CTRL || $past(state_reg) == ST_PARA))
        else $error("result without open frame");

    a_refused_para: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.frame_status == STATUS_REFUSED)
        |-> (out_data_reg.frame_kind == KIND_PARA))
        else $error("control frame refused");

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Testbench for crc8_framed_command_receiver_core: a directed stimulus table, then random
// frames, noise and broken frames under several start-byte settings, checked against a predictor.
// Depends on ccr_pkg, ccr_if.sv and the receiver core.

module tb;
    import ccr_pkg::*;

    localparam int unsigned CTRL_LEN = 4;
    localparam int unsigned PARA_LEN = 5;
    localparam int STALL_LIMIT = 1000;

    typedef enum logic [1:0] {RX_IDLE, RX_CTRL, RX_PARA} rx_phase_t;
    typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

    // ROW_CFG: a = control start byte, b = parameter start byte
    typedef struct {
        row_kind_t  kind;
        logic [7:0] a;
        logic [7:0] b;
        bit         panic;
        bit         fix_crc;
        bit         typed;
        out_beat_t  res;
    } stim_row_t;

    localparam out_beat_t NO_RES = '0;
    localparam out_beat_t CTRL_OK_ZERO =
        '{frame_kind: KIND_CTRL, frame_status: STATUS_OK, default: '0};
    localparam out_beat_t PARA_CRC_ERR_ZERO =
        '{frame_kind: KIND_PARA, frame_status: STATUS_CRC_ERR, default: '0};

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [7:0] cfg_wdata;

    ccr_in_if  in_ch ();
    ccr_out_if out_ch ();

    crc8_framed_command_receiver_core #(
        .CTRL_LEN (CTRL_LEN),
        .PARA_LEN (PARA_LEN)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    rx_phase_t  frm_state = RX_IDLE;
    int         byte_cnt = 0;
    logic [7:0] run_crc = '0;
    logic [7:0] cap [CAP_DEPTH];
    logic [7:0] ctrl_start = CTRL_START_RST;
    logic [7:0] para_start = PARA_START_RST;

    out_beat_t  frame_q [$];
    int         n_items = 0;
    int         n_err = 0;
    int         gap_pct = 0;
    int         stall_pct = 0;
    int         stall_left = 0;
    int         stuck = 0;

    stim_row_t dir_tab [0:28] = '{
        '{ROW_BEAT, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_BEAT, 8'hAA, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_BEAT, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_BEAT, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0, NO_RES},
        '{ROW_BEAT, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_BEAT, 8'h80, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_BEAT, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0, NO_RES},
        '{ROW_BEAT, 8'h55, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_BEAT, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_BEAT, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_BEAT, 8'h7F, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_BEAT, 8'h80, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_BEAT, 8'h01, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_BEAT, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0, NO_RES},
        // equal start bytes: control wins
        '{ROW_CFG,  8'h00, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_BEAT, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_BEAT, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_BEAT, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_BEAT, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_BEAT, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_BEAT, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1, CTRL_OK_ZERO},
        // bad CRC under panic: CRC error wins over refusal
        '{ROW_CFG,  8'hFF, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_BEAT, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_BEAT, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0, NO_RES},
        '{ROW_BEAT, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_BEAT, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0, NO_RES},
        '{ROW_BEAT, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_BEAT, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_BEAT, 8'h01, 8'h00, 1'b1, 1'b0, 1'b1, PARA_CRC_ERR_ZERO}
    };

    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        r = crc ^ b;
        repeat (8)
            r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        return r;
    endfunction

    // returns 0 when the byte is dropped while idle
    function automatic bit deframe(input in_beat_t beat, output bit done,
                                   output out_beat_t res);
        int  len;
        bit  para;
        done = 1'b0;
        res  = '0;
        if (frm_state == RX_IDLE)
        begin
            if (beat.rx_byte == ctrl_start)
                frm_state = RX_CTRL;
            else if (beat.rx_byte == para_start)
                frm_state = RX_PARA;
            else
                return 1'b0;
            byte_cnt = 0;
            run_crc  = crc8_next(8'h00, beat.rx_byte);
            return 1'b1;
        end
        para = (frm_state == RX_PARA);
        len  = para ? PARA_LEN : CTRL_LEN;
        if (byte_cnt < len)
        begin
            if (byte_cnt < CAP_DEPTH)
                cap[byte_cnt] = beat.rx_byte;
            run_crc  = crc8_next(run_crc, beat.rx_byte);
            byte_cnt = byte_cnt + 1;
            return 1'b1;
        end
        done = 1'b1;
        res.frame_kind = para ? KIND_PARA : KIND_CTRL;
        if (beat.rx_byte != run_crc)
            res.frame_status = STATUS_CRC_ERR;
        else if (para && beat.panic_mode)
            res.frame_status = STATUS_REFUSED;
        else
            res.frame_status = STATUS_OK;
        res.computed_crc = run_crc;
        if (para)
        begin
            res.param_index = cap[0];
            res.data_byte0  = cap[1];
            res.data_byte1  = cap[2];
            res.data_byte2  = cap[3];
            res.data_byte3  = cap[4];
        end
        else
        begin
            res.param_index = 8'h00;
            res.data_byte0  = cap[0];
            res.data_byte1  = cap[1];
            res.data_byte2  = cap[2];
            res.data_byte3  = cap[3];
        end
        frm_state = RX_IDLE;
        byte_cnt  = 0;
        run_crc   = 8'h00;
        return 1'b1;
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // called and returns at a falling edge; valid stays high afterwards
    task automatic send_beat(input logic [7:0] b, input bit panic,
                             input bit typed = 1'b0, input out_beat_t typed_res = '0);
        in_beat_t  beat;
        out_beat_t res;
        bit        done;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        beat.rx_byte    = b;
        beat.panic_mode = panic;
        in_ch.valid <= 1'b1;
        in_ch.data  <= beat;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        if (deframe(beat, done, res))
            n_items++;
        if (done)
            frame_q.push_back(typed ? typed_res : res);
        @(negedge clk);
    endtask

    task automatic close_frame();
        while (frm_state != RX_IDLE)
            send_beat(rand_byte(), 1'($urandom_range(0, 1)));
    endtask

    // sender holds off until every result is out, then rewrites both start bytes
    task automatic write_starts(input logic [7:0] c, input logic [7:0] p);
        close_frame();
        in_ch.valid <= 1'b0;
        while (frame_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_CTRL_START;
        cfg_wdata <= c;
        @(negedge clk);
        cfg_index <= REG_PARA_START;
        cfg_wdata <= p;
        @(negedge clk);
        cfg_we <= 1'b0;
        ctrl_start = c;
        para_start = p;
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
        begin
            stall_left   <= $urandom_range(0, 4);
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin : check_results
        out_beat_t want;
        out_beat_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (frame_q.size() == 0)
            begin
                n_err++;
                if (n_err <= 10)
                    $display("ERROR: result beat with none expected: %p", got);
            end
            else
            begin
                want = frame_q.pop_front();
                if (got.frame_kind !== want.frame_kind
                    || got.frame_status !== want.frame_status
                    || got.computed_crc !== want.computed_crc
                    || got.param_index !== want.param_index
                    || got.data_byte0 !== want.data_byte0
                    || got.data_byte1 !== want.data_byte1
                    || got.data_byte2 !== want.data_byte2
                    || got.data_byte3 !== want.data_byte3)
                begin
                    n_err++;
                    if (n_err <= 10)
                        $display("ERROR: mismatch at %0t\n  exp %p\n  got %p",
                                 $realtime, want, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stuck <= 0;
        else if (stuck >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            stuck <= stuck + 1;
    end

    initial
    begin
        logic [7:0] c;
        logic [7:0] p;
        logic [7:0] b;
        int         phase_base;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        cfg_we       = 1'b0;
        cfg_index    = REG_CTRL_START;
        cfg_wdata    = 8'h00;
        rst_n        = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        gap_pct   = 25;
        stall_pct = 25;
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_CFG)
                write_starts(dir_tab[i].a, dir_tab[i].b);
            else
                send_beat(dir_tab[i].fix_crc ? run_crc : dir_tab[i].a, dir_tab[i].panic,
                          dir_tab[i].typed, dir_tab[i].res);
        end

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    c = 8'h00;
                    p = 8'hFF;
                end
                1:
                begin
                    c = rand_byte();
                    p = c;
                end
                2:
                begin
                    c = CTRL_START_RST;
                    p = PARA_START_RST;
                end
                default:
                begin
                    c = 8'($urandom_range(0, 255));
                    p = 8'($urandom_range(0, 255));
                end
            endcase
            write_starts(c, p);
            gap_pct   = (ph == 5) ? 0 : ((ph % 2) ? 35 : 10);
            stall_pct = (ph == 5) ? 0 : ((ph % 2) ? 10 : 35);
            phase_base = n_items;
            while (n_items - phase_base < 85)
            begin
                case ($urandom_range(0, 9))
                    0:
                    begin
                        do
                            b = rand_byte();
                        while (b == ctrl_start || b == para_start);
                        send_beat(b, 1'($urandom_range(0, 1)));
                    end
                    1:
                        repeat ($urandom_range(1, 8))
                            send_beat(rand_byte(), 1'($urandom_range(0, 1)));
                    default:
                    begin
                        close_frame();
                        send_beat($urandom_range(0, 1) ? para_start : ctrl_start,
                                  1'($urandom_range(0, 1)));
                        while (byte_cnt < ((frm_state == RX_PARA) ? PARA_LEN : CTRL_LEN))
                            send_beat(rand_byte(), 1'($urandom_range(0, 1)));
                        send_beat(($urandom_range(0, 4) != 0) ? run_crc : rand_byte(),
                                  ($urandom_range(0, 2) == 0));
                    end
                endcase
            end
        end

        close_frame();
        in_ch.valid <= 1'b0;
        while (frame_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        if (n_err == 0 && frame_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
